// ===== rtl/core/r2n_pkg.sv =====
package r2n_pkg;

  // Fixed field widths
  localparam int COLOR_W = 8;
  localparam int CFG_W   = 13;
  localparam int ADDR_W  = 25;
  localparam int KIND_W  = 2;
  localparam int SUM_W   = 18;
  localparam int Q_W     = 10;

  // Configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'd1;

  localparam logic [CFG_W-1:0] FRAME_WIDTH_RESET  = 13'd640;
  localparam logic [CFG_W-1:0] FRAME_HEIGHT_RESET = 13'd480;

  // Byte kinds on the result stream
  localparam logic [KIND_W-1:0] KIND_LUMA = 2'd0;
  localparam logic [KIND_W-1:0] KIND_V    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_U    = 2'd2;

  // Queue between front and back ends
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;

  // BT.601 integer coefficients
  localparam logic signed [SUM_W-1:0] Y_R = 18'sd66;
  localparam logic signed [SUM_W-1:0] Y_G = 18'sd129;
  localparam logic signed [SUM_W-1:0] Y_B = 18'sd25;
  localparam logic signed [SUM_W-1:0] U_R = 18'sd38;
  localparam logic signed [SUM_W-1:0] U_G = 18'sd74;
  localparam logic signed [SUM_W-1:0] U_B = 18'sd112;
  localparam logic signed [SUM_W-1:0] V_R = 18'sd112;
  localparam logic signed [SUM_W-1:0] V_G = 18'sd94;
  localparam logic signed [SUM_W-1:0] V_B = 18'sd18;
  localparam logic signed [SUM_W-1:0] ROUND = 18'sd128;
  localparam logic signed [Q_W-1:0] Y_OFFSET = 10'sd16;
  localparam logic signed [Q_W-1:0] C_OFFSET = 10'sd128;

  typedef struct packed {
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
    logic [ADDR_W-1:0]  luma_addr;
    logic [ADDR_W-1:0]  chroma_addr;
    logic               has_chroma;
  } entry_t;

  typedef struct packed {
    logic [COLOR_W-1:0] y;
    logic [COLOR_W-1:0] u;
    logic [COLOR_W-1:0] v;
  } yuv_t;

  // floor(sum / 256) + offset, clamped to 0..255
  function automatic logic [COLOR_W-1:0] scale_clamp(input logic signed [SUM_W-1:0] sum,
                                                     input logic signed [Q_W-1:0] offset);
    logic signed [Q_W-1:0] q;
    q = Q_W'(sum >>> 8) + offset;
    if (q[Q_W-1]) begin
      scale_clamp = '0;
    end else if (q[8]) begin
      scale_clamp = '1;
    end else begin
      scale_clamp = q[COLOR_W-1:0];
    end
  endfunction

  function automatic yuv_t pixel_to_yuv(input logic [COLOR_W-1:0] r,
                                        input logic [COLOR_W-1:0] g,
                                        input logic [COLOR_W-1:0] b);
    logic signed [SUM_W-1:0] rs;
    logic signed [SUM_W-1:0] gs;
    logic signed [SUM_W-1:0] bs;
    logic signed [SUM_W-1:0] ys;
    logic signed [SUM_W-1:0] us;
    logic signed [SUM_W-1:0] vs;
    rs = $signed({10'd0, r});
    gs = $signed({10'd0, g});
    bs = $signed({10'd0, b});
    ys = Y_R * rs + Y_G * gs + Y_B * bs + ROUND;
    us = U_B * bs - U_R * rs - U_G * gs + ROUND;
    vs = V_R * rs - V_G * gs - V_B * bs + ROUND;
    pixel_to_yuv.y = scale_clamp(ys, Y_OFFSET);
    pixel_to_yuv.u = scale_clamp(us, C_OFFSET);
    pixel_to_yuv.v = scale_clamp(vs, C_OFFSET);
  endfunction

endpackage

// ===== rtl/core/r2n_front.sv =====
module r2n_front #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [r2n_pkg::COLOR_W-1:0]   red,
  input  logic [r2n_pkg::COLOR_W-1:0]   green,
  input  logic [r2n_pkg::COLOR_W-1:0]   blue,
  input  logic                          frame_start,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [r2n_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [r2n_pkg::CFG_W-1:0]     cfg_data,
  output logic                          push_valid,
  input  logic                          push_ready,
  output r2n_pkg::entry_t               push_data
);

  localparam int EW = $clog2(MAX_WIDTH + 1);
  localparam int EH = $clog2(MAX_HEIGHT + 1);
  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);
  localparam int AW = r2n_pkg::ADDR_W;

  logic [r2n_pkg::CFG_W-1:0] width_r, width_nxt;
  logic [r2n_pkg::CFG_W-1:0] height_r, height_nxt;
  logic [CW-1:0] col_r, col_nxt;
  logic [RW-1:0] row_r, row_nxt;
  logic [AW-1:0] luma_r, luma_nxt;
  logic [AW-1:0] chroma_r, chroma_nxt;

  logic [EW-1:0]    eff_w;
  logic [EH-1:0]    eff_h;
  logic [EW+EH-1:0] frame_pixels;
  logic [AW-1:0]    chroma_base;

  logic          in_fire;
  logic [CW-1:0] cur_col;
  logic [RW-1:0] cur_row;
  logic [AW-1:0] cur_luma;
  logic [AW-1:0] cur_chroma;
  logic          has_chroma;
  logic [EW-1:0] col_inc;
  logic [EH-1:0] row_inc;

  assign cfg_ready  = 1'b1;
  assign in_ready   = push_ready;
  assign push_valid = in_valid;
  assign in_fire    = in_valid && push_ready;

  // Effective frame size: zero acts as one, oversize clips to the maximum
  always_comb begin
    if (width_r == '0) begin
      eff_w = EW'(1);
    end else if (32'(width_r) > 32'(MAX_WIDTH)) begin
      eff_w = EW'(MAX_WIDTH);
    end else begin
      eff_w = EW'(width_r);
    end
    if (height_r == '0) begin
      eff_h = EH'(1);
    end else if (32'(height_r) > 32'(MAX_HEIGHT)) begin
      eff_h = EH'(MAX_HEIGHT);
    end else begin
      eff_h = EH'(height_r);
    end
  end

  assign frame_pixels = eff_w * eff_h;
  assign chroma_base  = AW'(frame_pixels);

  always_comb begin
    width_nxt  = width_r;
    height_nxt = height_r;
    if (cfg_valid) begin
      case (cfg_index)
        r2n_pkg::REG_FRAME_WIDTH:  width_nxt  = cfg_data;
        r2n_pkg::REG_FRAME_HEIGHT: height_nxt = cfg_data;
        default: ;
      endcase
    end
  end

  // Frame start restarts the position before this pixel is placed
  always_comb begin
    cur_col    = frame_start ? '0 : col_r;
    cur_row    = frame_start ? '0 : row_r;
    cur_luma   = frame_start ? '0 : luma_r;
    cur_chroma = frame_start ? chroma_base : chroma_r;
    has_chroma = !cur_row[0] && !cur_col[0];
    col_inc    = EW'(cur_col) + EW'(1);
    row_inc    = EH'(cur_row) + EH'(1);
  end

  always_comb begin
    col_nxt    = col_r;
    row_nxt    = row_r;
    luma_nxt   = luma_r;
    chroma_nxt = chroma_r;
    if (in_fire) begin
      col_nxt    = CW'(col_inc);
      row_nxt    = cur_row;
      luma_nxt   = cur_luma + AW'(1);
      chroma_nxt = has_chroma ? cur_chroma + AW'(2) : cur_chroma;
      if (col_inc >= eff_w) begin
        col_nxt = '0;
        row_nxt = RW'(row_inc);
        if (row_inc >= eff_h) begin
          // automatic wrap into the next frame
          row_nxt    = '0;
          luma_nxt   = '0;
          chroma_nxt = chroma_base;
        end
      end
    end
  end

  always_comb begin
    push_data.red         = red;
    push_data.green       = green;
    push_data.blue        = blue;
    push_data.luma_addr   = cur_luma;
    push_data.chroma_addr = cur_chroma;
    push_data.has_chroma  = has_chroma;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= r2n_pkg::FRAME_WIDTH_RESET;
      height_r <= r2n_pkg::FRAME_HEIGHT_RESET;
      col_r    <= '0;
      row_r    <= '0;
      luma_r   <= '0;
      chroma_r <= '0;
    end else begin
      width_r  <= width_nxt;
      height_r <= height_nxt;
      col_r    <= col_nxt;
      row_r    <= row_nxt;
      luma_r   <= luma_nxt;
      chroma_r <= chroma_nxt;
    end
  end

endmodule

// ===== rtl/core/r2n_queue.sv =====
module r2n_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push_valid,
  output logic            push_ready,
  input  r2n_pkg::entry_t push_data,
  output logic            pop_valid,
  input  logic            pop_ready,
  output r2n_pkg::entry_t pop_data
);

  localparam int PW = r2n_pkg::QPTR_W;

  r2n_pkg::entry_t mem_r [r2n_pkg::QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [PW:0]   count_r, count_nxt;
  logic          push_fire;
  logic          pop_fire;

  assign push_ready = count_r != (PW+1)'(r2n_pkg::QUEUE_DEPTH);
  assign pop_valid  = count_r != '0;
  assign pop_data   = mem_r[rd_ptr_r];
  assign push_fire  = push_valid && push_ready;
  assign pop_fire   = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = push_fire ? wr_ptr_r + PW'(1) : wr_ptr_r;
    rd_ptr_nxt = pop_fire ? rd_ptr_r + PW'(1) : rd_ptr_r;
    count_nxt  = count_r;
    if (push_fire && !pop_fire) begin
      count_nxt = count_r + (PW+1)'(1);
    end else if (pop_fire && !push_fire) begin
      count_nxt = count_r - (PW+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push_fire) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// ===== rtl/core/r2n_back.sv =====
module r2n_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        pop_valid,
  output logic                        pop_ready,
  input  r2n_pkg::entry_t             pop_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [r2n_pkg::COLOR_W-1:0] byte_value,
  output logic [r2n_pkg::ADDR_W-1:0]  byte_address,
  output logic [r2n_pkg::KIND_W-1:0]  byte_kind,
  output logic                        last_of_pixel
);

  localparam int AW = r2n_pkg::ADDR_W;

  // byte phase within one pixel
  localparam logic [1:0] PH_Y = 2'd0;
  localparam logic [1:0] PH_V = 2'd1;
  localparam logic [1:0] PH_U = 2'd2;

  // work stage: one converted pixel
  logic          a_valid_r, a_valid_nxt;
  logic [1:0]    a_phase_r, a_phase_nxt;
  r2n_pkg::yuv_t a_yuv_r, a_yuv_nxt;
  logic [AW-1:0] a_luma_r, a_luma_nxt;
  logic [AW-1:0] a_chroma_r, a_chroma_nxt;
  logic          a_has_chroma_r, a_has_chroma_nxt;

  // output register
  logic                        o_valid_r, o_valid_nxt;
  logic [r2n_pkg::COLOR_W-1:0] o_value_r, o_value_nxt;
  logic [AW-1:0]               o_addr_r, o_addr_nxt;
  logic [r2n_pkg::KIND_W-1:0]  o_kind_r, o_kind_nxt;
  logic                        o_last_r, o_last_nxt;

  logic o_load;
  logic emit;
  logic a_last;
  logic a_done;
  logic pop_fire;

  assign o_load    = !o_valid_r || out_ready;
  assign emit      = a_valid_r && o_load;
  assign a_last    = (a_phase_r == PH_U) || ((a_phase_r == PH_Y) && !a_has_chroma_r);
  assign a_done    = emit && a_last;
  assign pop_ready = !a_valid_r || a_done;
  assign pop_fire  = pop_valid && pop_ready;

  always_comb begin
    a_valid_nxt      = a_valid_r;
    a_phase_nxt      = a_phase_r;
    a_yuv_nxt        = a_yuv_r;
    a_luma_nxt       = a_luma_r;
    a_chroma_nxt     = a_chroma_r;
    a_has_chroma_nxt = a_has_chroma_r;
    if (pop_fire) begin
      a_valid_nxt      = 1'b1;
      a_phase_nxt      = PH_Y;
      a_yuv_nxt        = r2n_pkg::pixel_to_yuv(pop_data.red, pop_data.green, pop_data.blue);
      a_luma_nxt       = pop_data.luma_addr;
      a_chroma_nxt     = pop_data.chroma_addr;
      a_has_chroma_nxt = pop_data.has_chroma;
    end else if (a_done) begin
      a_valid_nxt = 1'b0;
    end else if (emit) begin
      case (a_phase_r)
        PH_Y:    a_phase_nxt = PH_V;
        PH_V:    a_phase_nxt = PH_U;
        default: a_phase_nxt = PH_Y;
      endcase
    end
  end

  always_comb begin
    o_valid_nxt = o_valid_r;
    o_value_nxt = o_value_r;
    o_addr_nxt  = o_addr_r;
    o_kind_nxt  = o_kind_r;
    o_last_nxt  = o_last_r;
    if (o_load) begin
      o_valid_nxt = a_valid_r;
      case (a_phase_r)
        PH_V: begin
          o_value_nxt = a_yuv_r.v;
          o_addr_nxt  = a_chroma_r;
          o_kind_nxt  = r2n_pkg::KIND_V;
          o_last_nxt  = 1'b0;
        end
        PH_U: begin
          o_value_nxt = a_yuv_r.u;
          o_addr_nxt  = a_chroma_r + AW'(1);
          o_kind_nxt  = r2n_pkg::KIND_U;
          o_last_nxt  = 1'b1;
        end
        default: begin
          o_value_nxt = a_yuv_r.y;
          o_addr_nxt  = a_luma_r;
          o_kind_nxt  = r2n_pkg::KIND_LUMA;
          o_last_nxt  = !a_has_chroma_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    a_phase_r      <= a_phase_nxt;
    a_yuv_r        <= a_yuv_nxt;
    a_luma_r       <= a_luma_nxt;
    a_chroma_r     <= a_chroma_nxt;
    a_has_chroma_r <= a_has_chroma_nxt;
    o_value_r      <= o_value_nxt;
    o_addr_r       <= o_addr_nxt;
    o_kind_r       <= o_kind_nxt;
    o_last_r       <= o_last_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      o_valid_r <= 1'b0;
    end else begin
      a_valid_r <= a_valid_nxt;
      o_valid_r <= o_valid_nxt;
    end
  end

  assign out_valid     = o_valid_r;
  assign byte_value    = o_value_r;
  assign byte_address  = o_addr_r;
  assign byte_kind     = o_kind_r;
  assign last_of_pixel = o_last_r;

endmodule

// ===== rtl/core/rgb_to_nv21_converter_unit.sv =====
// The Y byte of an accepted pixel goes through the queue, work stage and output register.
// Throughput: one byte per cycle from the single output register while out_tready is high; a pixel
//   with luma only gives one byte and a pixel with V and U gives three.
// The front end takes a pixel every cycle while the 4-entry queue has room.
// Reset (rst_n low, synchronous): counters, addresses, queue and valid flags clear;
//   width 640, height 480; chroma address is 0 until the first frame start or frame wrap.
module rgb_to_nv21_converter_unit #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // pixel requests
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [23:0]                   in_tdata,   // red[7:0], green[15:8], blue[23:16]
  input  logic                          in_tuser,   // frame_start[0]
  // byte write requests
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [39:0]                   out_tdata,  // byte_value[7:0], byte_address[32:8], 0
  output logic [1:0]                    out_tuser,  // byte_kind[1:0]
  output logic                          out_tlast,  // last_of_pixel
  // register writes
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [r2n_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [r2n_pkg::CFG_W-1:0]     cfg_data
);

  localparam int CLR = r2n_pkg::COLOR_W;
  localparam int AW  = r2n_pkg::ADDR_W;

  // front end -> queue
  logic            push_valid;
  logic            push_ready;
  r2n_pkg::entry_t push_data;

  // queue -> back end
  logic            pop_valid;
  logic            pop_ready;
  r2n_pkg::entry_t pop_data;

  // result fields
  logic [CLR-1:0] byte_value;
  logic [AW-1:0]  byte_address;

  // Front end: register file, raster position and plane addresses.
  // A frame start resets the position before the pixel is placed; the last pixel
  // of a frame wraps the position by itself.
  r2n_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .red         (in_tdata[7:0]),
    .green       (in_tdata[15:8]),
    .blue        (in_tdata[23:16]),
    .frame_start (in_tuser),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .push_valid  (push_valid),
    .push_ready  (push_ready),
    .push_data   (push_data)
  );

  // Short queue decouples pixel intake from byte output.
  r2n_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  // Back end: color conversion on pop, then Y and any V, U sequenced through one output register.
  r2n_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .pop_valid     (pop_valid),
    .pop_ready     (pop_ready),
    .pop_data      (pop_data),
    .out_valid     (out_tvalid),
    .out_ready     (out_tready),
    .byte_value    (byte_value),
    .byte_address  (byte_address),
    .byte_kind     (out_tuser),
    .last_of_pixel (out_tlast)
  );

  assign out_tdata = {7'd0, byte_address, byte_value};

`ifndef SYNTH
  // A U byte always closes its pixel
  a_u_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == r2n_pkg::KIND_U) |-> out_tlast)
    else $error("U byte without last_of_pixel");

  // A luma byte that does not close its pixel is followed at once by its V byte
  a_luma_then_v: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && (out_tuser == r2n_pkg::KIND_LUMA) && !out_tlast
    |=> out_tvalid && (out_tuser == r2n_pkg::KIND_V))
    else $error("V byte did not follow luma byte");

  // A V byte is followed at once by the U byte one address above
  a_v_then_u: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && (out_tuser == r2n_pkg::KIND_V)
    |=> out_tvalid && (out_tuser == r2n_pkg::KIND_U)
        && (out_tdata[32:8] == $past(out_tdata[32:8]) + 25'd1))
    else $error("U byte did not follow V byte");
`endif

endmodule

// ===== tb/tb_rgb_to_nv21_converter_unit.sv =====
`timescale 1ns / 1ps

module tb_rgb_to_nv21_converter_unit;

  localparam int MAX_W      = 4096;
  localparam int MAX_H      = 4096;
  localparam int STALL_MAX  = 1000;  // cycles with no request moving on any port
  localparam int LONG_HOLD  = 300;   // receiver hold-off, fills the queue
  localparam int SETTLE     = 8;     // quiet cycles after the last byte
  localparam int RAND_ITEMS = 300;

  // One byte write as seen on the result stream.
  typedef struct {
    logic [r2n_pkg::COLOR_W-1:0] value;
    logic [r2n_pkg::ADDR_W-1:0]  addr;
    logic [r2n_pkg::KIND_W-1:0]  kind;
    logic                        last;
  } nv21_write_t;

  // Tracks frame position and chroma base, predicts the byte writes of each pixel
  // and compares them against the stream in order.
  class nv21_write_checker;
    logic [r2n_pkg::CFG_W-1:0]  width_reg;
    logic [r2n_pkg::CFG_W-1:0]  height_reg;
    logic [r2n_pkg::CFG_W-1:0]  col;   // one bit wider than the block's counter
    logic [r2n_pkg::CFG_W-1:0]  row;
    logic [r2n_pkg::ADDR_W-1:0] luma_addr;
    logic [r2n_pkg::ADDR_W-1:0] chroma_addr;
    nv21_write_t                pending_writes[$];
    int                         errors;

    function new();
      width_reg   = r2n_pkg::FRAME_WIDTH_RESET;
      height_reg  = r2n_pkg::FRAME_HEIGHT_RESET;
      col         = '0;
      row         = '0;
      luma_addr   = '0;
      chroma_addr = '0;  // chroma lands at 0 until the first frame start or wrap
      errors      = 0;
    endfunction

    function int eff_size(logic [r2n_pkg::CFG_W-1:0] v, int maxv);
      if (v == 0) return 1;
      if (v > maxv) return maxv;
      return v;
    endfunction

    function void restart_frame();
      col         = '0;
      row         = '0;
      luma_addr   = '0;
      chroma_addr = r2n_pkg::ADDR_W'(eff_size(width_reg, MAX_W) * eff_size(height_reg, MAX_H));
    endfunction

    // floor(sum/256) + offset, clamped to a byte
    function logic [r2n_pkg::COLOR_W-1:0] scale_clamp(int sum, int offset);
      int q;
      q = (sum >>> 8) + offset;
      if (q < 0) return '0;
      if (q > 255) return '1;
      return q[r2n_pkg::COLOR_W-1:0];
    endfunction

    function void set_reg(logic [r2n_pkg::CFG_IDX_W-1:0] idx,
                          logic [r2n_pkg::CFG_W-1:0] val);
      if (idx == r2n_pkg::REG_FRAME_WIDTH) width_reg = val;
      else if (idx == r2n_pkg::REG_FRAME_HEIGHT) height_reg = val;
    endfunction

    function void push_write(logic [r2n_pkg::COLOR_W-1:0] value,
                             logic [r2n_pkg::ADDR_W-1:0] addr,
                             logic [r2n_pkg::KIND_W-1:0] kind, logic last);
      nv21_write_t w;
      w.value = value;
      w.addr  = addr;
      w.kind  = kind;
      w.last  = last;
      pending_writes.push_back(w);
    endfunction

    function void take_pixel(logic [r2n_pkg::COLOR_W-1:0] r, logic [r2n_pkg::COLOR_W-1:0] g,
                             logic [r2n_pkg::COLOR_W-1:0] b, logic frame_start);
      int ri;
      int gi;
      int bi;
      logic [r2n_pkg::COLOR_W-1:0] y;
      logic [r2n_pkg::COLOR_W-1:0] u;
      logic [r2n_pkg::COLOR_W-1:0] v;
      logic with_chroma;
      if (frame_start) restart_frame();
      ri = r;
      gi = g;
      bi = b;
      y = scale_clamp(66 * ri + 129 * gi + 25 * bi + 128, 16);
      u = scale_clamp(-38 * ri - 74 * gi + 112 * bi + 128, 128);
      v = scale_clamp(112 * ri - 94 * gi - 18 * bi + 128, 128);
      with_chroma = !row[0] && !col[0];
      push_write(y, luma_addr, r2n_pkg::KIND_LUMA, !with_chroma);
      if (with_chroma) begin
        push_write(v, chroma_addr, r2n_pkg::KIND_V, 1'b0);
        push_write(u, chroma_addr + 1'b1, r2n_pkg::KIND_U, 1'b1);
        chroma_addr = chroma_addr + 2'd2;
      end
      luma_addr = luma_addr + 1'b1;
      // >= so a counter left beyond a shrunk size wraps on this advance
      col = col + 1'b1;
      if (col >= eff_size(width_reg, MAX_W)) begin
        col = '0;
        row = row + 1'b1;
        if (row >= eff_size(height_reg, MAX_H)) restart_frame();
      end
    endfunction

    function void check_write(logic [r2n_pkg::COLOR_W-1:0] value,
                              logic [r2n_pkg::ADDR_W-1:0] addr,
                              logic [r2n_pkg::KIND_W-1:0] kind, logic last);
      nv21_write_t w;
      if (pending_writes.size() == 0) begin
        $error("byte write with none predicted: value %0d address %0d kind %0d",
               value, addr, kind);
        errors++;
        return;
      end
      w = pending_writes.pop_front();
      if (value !== w.value) begin
        $error("byte_value: expected %0d, got %0d", w.value, value);
        errors++;
      end
      if (addr !== w.addr) begin
        $error("byte_address: expected %0d, got %0d", w.addr, addr);
        errors++;
      end
      if (kind !== w.kind) begin
        $error("byte_kind: expected %0d, got %0d", w.kind, kind);
        errors++;
      end
      if (last !== w.last) begin
        $error("last_of_pixel: expected %0d, got %0d", w.last, last);
        errors++;
      end
    endfunction

    function int pending();
      return pending_writes.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  // pixel requests
  logic                          in_tvalid = 1'b0;
  logic                          in_tready;
  logic [23:0]                   in_tdata = '0;   // red[7:0], green[15:8], blue[23:16]
  logic                          in_tuser = 1'b0; // frame_start[0]
  // byte write requests
  logic                          out_tvalid;
  logic                          out_tready = 1'b0;
  logic [39:0]                   out_tdata;       // byte_value[7:0], byte_address[32:8], 0
  logic [1:0]                    out_tuser;       // byte_kind[1:0]
  logic                          out_tlast;       // last_of_pixel
  // register writes
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [r2n_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [r2n_pkg::CFG_W-1:0]     cfg_data = '0;

  nv21_write_checker tracker = new();

  bit hold_request = 1'b0;  // asks the receiver for one long hold-off
  int burst_left = 0;       // pixels left in the current sender burst

  rgb_to_nv21_converter_unit #(
    .MAX_WIDTH (MAX_W),
    .MAX_HEIGHT(MAX_H)
  ) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Offer one pixel and return at the edge that accepts it. A new burst may
  // start with a gap, so valid drops only between bursts.
  task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
                            input logic frame_start);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata  <= {b, g, r};
    in_tuser  <= frame_start;
    do @(posedge clk); while (!in_tready);
    tracker.take_pixel(r, g, b, frame_start);
  endtask

  // Stop offering and wait until every predicted byte has come out, then a
  // few quiet cycles so the block is surely idle before a register write.
  task automatic drain();
    in_tvalid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [r2n_pkg::CFG_IDX_W-1:0] idx,
                           input logic [r2n_pkg::CFG_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    tracker.set_reg(idx, val);
  endtask

  // Back-to-back writes keep valid high; it drops once after the last one.
  task automatic set_frame(input bit set_w, input logic [r2n_pkg::CFG_W-1:0] w,
                           input bit set_h, input logic [r2n_pkg::CFG_W-1:0] h);
    if (set_w) write_reg(r2n_pkg::REG_FRAME_WIDTH, w);
    if (set_h) write_reg(r2n_pkg::REG_FRAME_HEIGHT, h);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [7:0] pick_color();
    if ($urandom_range(0, 7) == 0) return $urandom_range(0, 1) ? 8'hff : 8'h00;
    return 8'($urandom_range(0, 255));
  endfunction

  // Mostly tiny frames so rows and frames wrap often; now and then the
  // register extremes and sizes past the maximum.
  function automatic logic [r2n_pkg::CFG_W-1:0] pick_size(input int small_max);
    case ($urandom_range(0, 11))
      0:       return '0;
      1:       return '1;
      2:       return r2n_pkg::CFG_W'(MAX_W);
      3:       return r2n_pkg::CFG_W'($urandom_range(MAX_W + 1, 8190));
      4:       return r2n_pkg::CFG_W'($urandom_range(1, 64));
      default: return r2n_pkg::CFG_W'($urandom_range(1, small_max));
    endcase
  endfunction

  // Receiver: segments of always-ready, random stalls and a sparse pattern,
  // plus one long hold-off once the random part asks for it.
  initial begin
    int mode;
    int seg;
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end
      mode = $urandom_range(0, 2);
      seg  = $urandom_range(4, 24);
      for (int k = 0; k < seg; k++) begin
        case (mode)
          0:       out_tready <= 1'b1;
          1:       out_tready <= ($urandom_range(0, 3) != 0);
          default: out_tready <= (k % 3 == 0);
        endcase
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      tracker.check_write(out_tdata[7:0], out_tdata[32:8], out_tuser, out_tlast);
  end

  // Watchdog: any request moving on any port restarts the count.
  initial begin
    int stale;
    stale = 0;
    while (stale < STALL_MAX) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
        stale = 0;
      else
        stale++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    int sent;
    int n_items;
    int which;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset sizes, no frame start yet: chroma goes from address 0.
    // All eight color corners, then a mid-scale pixel.
    for (int i = 0; i < 8; i++)
      send_pixel({8{i[0]}}, {8{i[1]}}, {8{i[2]}}, 1'b0);
    send_pixel(8'h80, 8'h7f, 8'h01, 1'b0);
    // Frame start on an odd column: counters restart, chroma base 640*480.
    send_pixel(8'h12, 8'hed, 8'h5a, 1'b1);
    drain();

    // Odd width, two rows: 6 pixels per frame, then the automatic wrap.
    set_frame(1'b1, 13'd3, 1'b1, 13'd2);
    send_pixel(8'hff, 8'h00, 8'h80, 1'b1);
    for (int i = 0; i < 7; i++)
      send_pixel(pick_color(), pick_color(), pick_color(), 1'b0);
    drain();

    // Zero sizes act as 1; set mid-frame with column 2 beyond the new width.
    set_frame(1'b1, 13'd0, 1'b1, 13'd0);
    repeat (3) send_pixel(pick_color(), pick_color(), pick_color(), 1'b0);
    drain();

    // Width past the maximum clamps to it, height at the maximum; chroma base 4096*4096.
    set_frame(1'b1, 13'h1fff, 1'b1, 13'd4096);
    send_pixel(8'h00, 8'hff, 8'hff, 1'b1);
    repeat (2) send_pixel(pick_color(), pick_color(), pick_color(), 1'b0);
    drain();

    // Random phases. The first is long and carries the receiver hold-off so
    // the queue fills and in_tready drops while pixels keep coming.
    hold_request = 1'b1;
    sent = 0;
    n_items = 80;
    while (sent < RAND_ITEMS) begin
      for (int i = 0; i < n_items; i++) begin
        send_pixel(pick_color(), pick_color(), pick_color(),
                   (i == 0) ? 1'($urandom_range(0, 1)) : ($urandom_range(0, 23) == 0));
      end
      sent += n_items;
      drain();
      which = $urandom_range(0, 2);
      set_frame(which != 1, pick_size(9), which != 0, pick_size(6));
      n_items = $urandom_range(10, 40);
    end

    in_tvalid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (tracker.errors == 0 && tracker.pending() == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
